FILE: src/trps_pkg.sv
package trps_pkg;

    // Field widths
    localparam int RATE_W    = 24;
    localparam int RATE_FRAC = 19;
    localparam int UNI_W     = 32;
    localparam int LIMIT_W   = 4;
    localparam int DRAW_W    = 5;
    localparam int W_W       = 64;
    localparam int HALF_W    = 32;
    localparam int PP_W      = HALF_W + RATE_W;      // one partial product
    localparam int PROD_W    = W_W + RATE_W;         // full weight times rate
    localparam int SHARE_W   = UNI_W + 1;            // share can reach exactly 1.0
    localparam int DIVJ_W    = 5;                    // divisor width of the divide-by-count unit
    localparam int CNT_W     = 5;

    // Defaults and reset values
    localparam int              MAX_LIMIT_DEF = 15;
    localparam logic [LIMIT_W-1:0] LIMIT_RST  = 4'd8;
    localparam logic [W_W-1:0]  ONE_Q24       = 64'h0000_0000_0100_0000;

    // Divide-by-count unit retires this many quotient bits per cycle
    localparam int DJ_BITS     = 8;
    localparam logic [CNT_W-1:0] DJ_CNT_INIT = CNT_W'(W_W / DJ_BITS - 1);
    localparam logic [CNT_W-1:0] SD_CNT_INIT = CNT_W'(UNI_W - 1);

    // Datapath operations
    typedef enum logic [3:0] {
        OP_NOP,
        OP_INIT,
        OP_MUL_LO,
        OP_MUL_HI,
        OP_PROD_SUM,
        OP_DJ_INIT,
        OP_DJ_STEP,
        OP_W_STORE,
        OP_S_INIT,
        OP_SD_INIT,
        OP_SD_STEP,
        OP_ACCUM,
        OP_INC_J,
        OP_EMIT_HIT,
        OP_EMIT_CLAMP
    } t_op;

    // Jump conditions
    typedef enum logic [2:0] {
        COND_NEXT,
        COND_ALWAYS,
        COND_J_EQ_LIM,
        COND_CNT_NZ,
        COND_HIT
    } t_cond;

    // Wait conditions: step holds while the named side is not ready
    typedef enum logic [1:0] {
        HOLD_NONE,
        HOLD_IN,
        HOLD_OUT
    } t_hold;

    localparam int STEP_W = 5;

    typedef struct packed {
        t_op                op;
        t_cond              cond;
        t_hold              hold;
        logic [STEP_W-1:0]  target;
    } t_cword;

    // Datapath status seen by the sequencer
    typedef struct packed {
        logic j_eq_lim;
        logic cnt_nz;
        logic hit;
    } t_stat;

    // Program addresses
    localparam logic [STEP_W-1:0] ST_WAIT      = 5'd0;
    localparam logic [STEP_W-1:0] ST_W_CHECK   = 5'd1;
    localparam logic [STEP_W-1:0] ST_MUL_LO    = 5'd2;
    localparam logic [STEP_W-1:0] ST_MUL_HI    = 5'd3;
    localparam logic [STEP_W-1:0] ST_PROD_SUM  = 5'd4;
    localparam logic [STEP_W-1:0] ST_DJ_INIT   = 5'd5;
    localparam logic [STEP_W-1:0] ST_DJ_STEP   = 5'd6;
    localparam logic [STEP_W-1:0] ST_W_STORE   = 5'd7;
    localparam logic [STEP_W-1:0] ST_S_INIT    = 5'd8;
    localparam logic [STEP_W-1:0] ST_S_READ    = 5'd9;
    localparam logic [STEP_W-1:0] ST_SD_INIT   = 5'd10;
    localparam logic [STEP_W-1:0] ST_SD_STEP   = 5'd11;
    localparam logic [STEP_W-1:0] ST_ACCUM     = 5'd12;
    localparam logic [STEP_W-1:0] ST_TEST      = 5'd13;
    localparam logic [STEP_W-1:0] ST_NEXT      = 5'd14;
    localparam logic [STEP_W-1:0] ST_LOOP      = 5'd15;
    localparam logic [STEP_W-1:0] ST_EMIT_HIT  = 5'd16;
    localparam logic [STEP_W-1:0] ST_EMIT_CLMP = 5'd17;

    function automatic t_cword mk_cw(input t_op op, input t_cond cond, input t_hold hold,
                                     input logic [STEP_W-1:0] target);
        t_cword w;
        w.op     = op;
        w.cond   = cond;
        w.hold   = hold;
        w.target = target;
        return w;
    endfunction

    // Control store
    function automatic t_cword ucode(input logic [STEP_W-1:0] pc);
        t_cword w;
        case (pc)
            ST_WAIT:      w = mk_cw(OP_INIT,       COND_NEXT,     HOLD_IN,   ST_WAIT);
            ST_W_CHECK:   w = mk_cw(OP_NOP,        COND_J_EQ_LIM, HOLD_NONE, ST_S_INIT);
            ST_MUL_LO:    w = mk_cw(OP_MUL_LO,     COND_NEXT,     HOLD_NONE, ST_WAIT);
            ST_MUL_HI:    w = mk_cw(OP_MUL_HI,     COND_NEXT,     HOLD_NONE, ST_WAIT);
            ST_PROD_SUM:  w = mk_cw(OP_PROD_SUM,   COND_NEXT,     HOLD_NONE, ST_WAIT);
            ST_DJ_INIT:   w = mk_cw(OP_DJ_INIT,    COND_NEXT,     HOLD_NONE, ST_WAIT);
            ST_DJ_STEP:   w = mk_cw(OP_DJ_STEP,    COND_CNT_NZ,   HOLD_NONE, ST_DJ_STEP);
            ST_W_STORE:   w = mk_cw(OP_W_STORE,    COND_ALWAYS,   HOLD_NONE, ST_W_CHECK);
            ST_S_INIT:    w = mk_cw(OP_S_INIT,     COND_NEXT,     HOLD_NONE, ST_WAIT);
            ST_S_READ:    w = mk_cw(OP_NOP,        COND_NEXT,     HOLD_NONE, ST_WAIT);
            ST_SD_INIT:   w = mk_cw(OP_SD_INIT,    COND_NEXT,     HOLD_NONE, ST_WAIT);
            ST_SD_STEP:   w = mk_cw(OP_SD_STEP,    COND_CNT_NZ,   HOLD_NONE, ST_SD_STEP);
            ST_ACCUM:     w = mk_cw(OP_ACCUM,      COND_NEXT,     HOLD_NONE, ST_WAIT);
            ST_TEST:      w = mk_cw(OP_NOP,        COND_HIT,      HOLD_NONE, ST_EMIT_HIT);
            ST_NEXT:      w = mk_cw(OP_INC_J,      COND_J_EQ_LIM, HOLD_NONE, ST_EMIT_CLMP);
            ST_LOOP:      w = mk_cw(OP_NOP,        COND_ALWAYS,   HOLD_NONE, ST_S_READ);
            ST_EMIT_HIT:  w = mk_cw(OP_EMIT_HIT,   COND_ALWAYS,   HOLD_OUT,  ST_WAIT);
            ST_EMIT_CLMP: w = mk_cw(OP_EMIT_CLAMP, COND_ALWAYS,   HOLD_OUT,  ST_WAIT);
            default:      w = mk_cw(OP_NOP,        COND_ALWAYS,   HOLD_NONE, ST_WAIT);
        endcase
        return w;
    endfunction

endpackage

FILE: src/trps_seq.sv
module trps_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  trps_pkg::t_stat  i_stat,
    input  logic             i_in_valid,
    input  logic             i_out_busy,
    output trps_pkg::t_op    o_op,
    output logic             o_in_ready
);

    logic [trps_pkg::STEP_W-1:0] r_pc, n_pc;
    trps_pkg::t_cword             cw;
    logic                         held;
    logic                         taken;

    // Step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= trps_pkg::ST_WAIT;
        end else begin
            r_pc <= n_pc;
        end
    end

    // Fetch, evaluate wait and jump conditions
    always_comb begin
        cw = trps_pkg::ucode(r_pc);

        case (cw.hold)
            trps_pkg::HOLD_IN:  held = !i_in_valid;
            trps_pkg::HOLD_OUT: held = i_out_busy;
            default:            held = 1'b0;
        endcase

        case (cw.cond)
            trps_pkg::COND_ALWAYS:   taken = 1'b1;
            trps_pkg::COND_J_EQ_LIM: taken = i_stat.j_eq_lim;
            trps_pkg::COND_CNT_NZ:   taken = i_stat.cnt_nz;
            trps_pkg::COND_HIT:      taken = i_stat.hit;
            default:                 taken = 1'b0;
        endcase

        if (held) begin
            n_pc = r_pc;
        end else if (taken) begin
            n_pc = cw.target;
        end else begin
            n_pc = r_pc + trps_pkg::STEP_W'(1);
        end

        // Refuse requests while in reset
        o_op       = held ? trps_pkg::OP_NOP : cw.op;
        o_in_ready = i_rst_n && (cw.hold == trps_pkg::HOLD_IN);
    end

endmodule

FILE: src/trps_dpath.sv
module trps_dpath #(
    parameter int MAX_LIMIT = trps_pkg::MAX_LIMIT_DEF
) (
    input  logic                          i_clk,
    input  trps_pkg::t_op                 i_op,
    input  logic [trps_pkg::RATE_W-1:0]   i_rate,
    input  logic [trps_pkg::UNI_W-1:0]    i_uniform,
    input  logic [trps_pkg::LIMIT_W-1:0]  i_count_limit,
    output trps_pkg::t_stat               o_stat,
    output logic [trps_pkg::DRAW_W-1:0]   o_draw
);

    localparam int J_W   = $clog2(MAX_LIMIT + 1);
    localparam int SHF_W = trps_pkg::PROD_W - trps_pkg::RATE_FRAC;

    logic [trps_pkg::RATE_W-1:0]  r_rate, n_rate;
    logic [trps_pkg::UNI_W-1:0]   r_uniform, n_uniform;
    logic [J_W-1:0]               r_j, n_j, r_lim, n_lim;
    logic [trps_pkg::W_W-1:0]     r_w, n_w, r_total, n_total;
    logic [trps_pkg::W_W-1:0]     r_dvd, n_dvd, r_srem, n_srem;
    logic [trps_pkg::PP_W-1:0]    r_pp, n_pp;
    logic [trps_pkg::PROD_W-1:0]  r_prod, n_prod;
    logic [trps_pkg::DIVJ_W-1:0]  r_djrem, n_djrem;
    logic [trps_pkg::SHARE_W-1:0] r_q, n_q, r_cum, n_cum;
    logic [trps_pkg::CNT_W-1:0]   r_cnt, n_cnt;

    // Weight store, one entry per count
    logic [trps_pkg::W_W-1:0]     r_wmem [0:MAX_LIMIT];
    logic [trps_pkg::W_W-1:0]     r_rd;
    logic                         mem_we;
    logic [J_W-1:0]               mem_wa;
    logic [trps_pkg::W_W-1:0]     mem_wd;

    logic [trps_pkg::HALF_W-1:0]  mul_a;
    logic [trps_pkg::PP_W-1:0]    mul_p;
    logic [SHF_W-1:0]             shifted;
    logic [trps_pkg::W_W:0]       tot_sum;
    logic [J_W-1:0]               lim_sel;

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_rate    <= n_rate;
        r_uniform <= n_uniform;
        r_j       <= n_j;
        r_lim     <= n_lim;
        r_w       <= n_w;
        r_total   <= n_total;
        r_dvd     <= n_dvd;
        r_srem    <= n_srem;
        r_pp      <= n_pp;
        r_prod    <= n_prod;
        r_djrem   <= n_djrem;
        r_q       <= n_q;
        r_cum     <= n_cum;
        r_cnt     <= n_cnt;
    end

    // Weight store: one write, one registered read at the current count
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_wmem[mem_wa] <= mem_wd;
        end
        r_rd <= r_wmem[r_j];
    end

    assign mem_we = (i_op == trps_pkg::OP_INIT) || (i_op == trps_pkg::OP_W_STORE);
    assign mem_wa = (i_op == trps_pkg::OP_INIT) ? '0 : r_j;
    assign mem_wd = (i_op == trps_pkg::OP_INIT) ? trps_pkg::ONE_Q24 : r_dvd;

    // Single shared multiplier: one half of the weight times the rate
    assign mul_a = (i_op == trps_pkg::OP_MUL_HI) ? r_w[trps_pkg::W_W-1:trps_pkg::HALF_W]
                                                 : r_w[trps_pkg::HALF_W-1:0];
    assign mul_p = trps_pkg::PP_W'(mul_a) * trps_pkg::PP_W'(r_rate);

    // Product rescaled from rate fraction bits
    assign shifted = r_prod[trps_pkg::PROD_W-1:trps_pkg::RATE_FRAC];

    // Saturating running total
    assign tot_sum = {1'b0, r_total} + {1'b0, r_dvd};

    // Clamp the configured limit to the store depth
    always_comb begin
        if (int'(i_count_limit) > MAX_LIMIT) begin
            lim_sel = J_W'(MAX_LIMIT);
        end else begin
            lim_sel = J_W'(i_count_limit);
        end
    end

    // Operation decode
    always_comb begin
        logic [trps_pkg::W_W-1:0]    dvd;
        logic [trps_pkg::DIVJ_W-1:0] rem;
        logic [trps_pkg::DIVJ_W:0]   t;
        logic [trps_pkg::W_W-1:0]    sh;

        n_rate    = r_rate;
        n_uniform = r_uniform;
        n_j       = r_j;
        n_lim     = r_lim;
        n_w       = r_w;
        n_total   = r_total;
        n_dvd     = r_dvd;
        n_srem    = r_srem;
        n_pp      = r_pp;
        n_prod    = r_prod;
        n_djrem   = r_djrem;
        n_q       = r_q;
        n_cum     = r_cum;
        n_cnt     = r_cnt;
        dvd       = r_dvd;
        rem       = r_djrem;
        t         = '0;
        sh        = {r_srem[trps_pkg::W_W-2:0], 1'b0};

        case (i_op)
            // Take the request, seed the first weight and total
            trps_pkg::OP_INIT: begin
                n_rate    = i_rate;
                n_uniform = i_uniform;
                n_lim     = lim_sel;
                n_j       = '0;
                n_w       = trps_pkg::ONE_Q24;
                n_total   = trps_pkg::ONE_Q24;
            end
            trps_pkg::OP_MUL_LO: begin
                n_j  = r_j + J_W'(1);
                n_pp = mul_p;
            end
            trps_pkg::OP_MUL_HI: begin
                n_prod = trps_pkg::PROD_W'(r_pp);
                n_pp   = mul_p;
            end
            trps_pkg::OP_PROD_SUM: begin
                n_prod = r_prod + {r_pp, {trps_pkg::HALF_W{1'b0}}};
            end
            // Load dividend, saturating when the scaled product overflows
            trps_pkg::OP_DJ_INIT: begin
                if (|shifted[SHF_W-1:trps_pkg::W_W]) begin
                    n_dvd = '1;
                end else begin
                    n_dvd = shifted[trps_pkg::W_W-1:0];
                end
                n_djrem = '0;
                n_cnt   = trps_pkg::DJ_CNT_INIT;
            end
            // Restoring divide by the count, several quotient bits per cycle
            trps_pkg::OP_DJ_STEP: begin
                for (int k = 0; k < trps_pkg::DJ_BITS; k++) begin
                    t = {rem, dvd[trps_pkg::W_W-1]};
                    if (t >= (trps_pkg::DIVJ_W + 1)'(r_j)) begin
                        t   = t - (trps_pkg::DIVJ_W + 1)'(r_j);
                        dvd = {dvd[trps_pkg::W_W-2:0], 1'b1};
                    end else begin
                        dvd = {dvd[trps_pkg::W_W-2:0], 1'b0};
                    end
                    rem = t[trps_pkg::DIVJ_W-1:0];
                end
                n_dvd   = dvd;
                n_djrem = rem;
                n_cnt   = r_cnt - trps_pkg::CNT_W'(1);
            end
            trps_pkg::OP_W_STORE: begin
                n_w     = r_dvd;
                n_total = tot_sum[trps_pkg::W_W] ? '1 : tot_sum[trps_pkg::W_W-1:0];
            end
            trps_pkg::OP_S_INIT: begin
                n_j   = '0;
                n_cum = '0;
            end
            // Share division: integer bit first
            trps_pkg::OP_SD_INIT: begin
                if (r_rd >= r_total) begin
                    n_srem = r_rd - r_total;
                    n_q    = trps_pkg::SHARE_W'(1);
                end else begin
                    n_srem = r_rd;
                    n_q    = '0;
                end
                n_cnt = trps_pkg::SD_CNT_INIT;
            end
            // Share division: one fraction bit a cycle, shifted-out bit kept as carry
            trps_pkg::OP_SD_STEP: begin
                if (r_srem[trps_pkg::W_W-1] || (sh >= r_total)) begin
                    n_srem = sh - r_total;
                    n_q    = {r_q[trps_pkg::SHARE_W-2:0], 1'b1};
                end else begin
                    n_srem = sh;
                    n_q    = {r_q[trps_pkg::SHARE_W-2:0], 1'b0};
                end
                n_cnt = r_cnt - trps_pkg::CNT_W'(1);
            end
            trps_pkg::OP_ACCUM: begin
                n_cum = r_cum + r_q;
            end
            trps_pkg::OP_INC_J: begin
                n_j = r_j + J_W'(1);
            end
            default: begin
            end
        endcase
    end

    // Status back to the sequencer
    assign o_stat.j_eq_lim = (r_j == r_lim);
    assign o_stat.cnt_nz   = (r_cnt != '0);
    assign o_stat.hit      = ({1'b0, r_uniform} <= r_cum);

    // One-based result position
    assign o_draw = (i_op == trps_pkg::OP_EMIT_CLAMP)
                  ? trps_pkg::DRAW_W'(r_lim) + trps_pkg::DRAW_W'(1)
                  : trps_pkg::DRAW_W'(r_j) + trps_pkg::DRAW_W'(1);

endmodule

FILE: src/truncated_poisson_sampler_top.sv
// Truncated Poisson sampler by inverse transform. Each request carries a Q5.19 rate and a
// Q0.32 uniform number; the block forms the weights 1, rate, rate^2/2!, ... up to the
// configured count limit (capped at MAX_LIMIT), turns each into a truncated Q1.32 share of
// their total and returns the first one-based position whose running share reaches the
// uniform number, or limit+1 with the clamp flag when none does. A small microcoded
// sequencer drives one shared 32x24 multiplier, a divide-by-count unit (8 quotient bits a
// cycle) and a one-bit-a-cycle share divider. The emit step waits while the output
// register still holds an untaken result. Requests are taken one at a time; a finished
// result waits in the output register while the next request is accepted and worked on.
// Write count_limit only while the block idles.
module truncated_poisson_sampler_top #(
    parameter int MAX_LIMIT = trps_pkg::MAX_LIMIT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration: count_limit
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_data,
    // Request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // [23:0] rate, [55:24] uniform
    // Result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [4:0] draw, [7:5] zero
    output logic [0:0]  m_axis_tuser    // [0] clamped
);

    logic [trps_pkg::LIMIT_W-1:0] r_count_limit;
    logic                         r_out_valid;
    logic [trps_pkg::DRAW_W-1:0]  r_draw;
    logic                         r_clamped;

    trps_pkg::t_op                op;
    trps_pkg::t_stat              stat;
    logic                         out_busy;
    logic                         emit;
    logic [trps_pkg::DRAW_W-1:0]  draw;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count_limit <= trps_pkg::LIMIT_RST;
        end else if (i_cfg_valid) begin
            r_count_limit <= i_cfg_data;
        end
    end

    assign o_cfg_ready = i_rst_n;

    trps_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_stat     (stat),
        .i_in_valid (s_axis_tvalid),
        .i_out_busy (out_busy),
        .o_op       (op),
        .o_in_ready (s_axis_tready)
    );

    trps_dpath #(
        .MAX_LIMIT (MAX_LIMIT)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_op          (op),
        .i_rate        (s_axis_tdata[23:0]),
        .i_uniform     (s_axis_tdata[55:24]),
        .i_count_limit (r_count_limit),
        .o_stat        (stat),
        .o_draw        (draw)
    );

    // Output register: hold a result until it is taken
    assign out_busy = r_out_valid && !m_axis_tready;
    assign emit     = (op == trps_pkg::OP_EMIT_HIT) || (op == trps_pkg::OP_EMIT_CLAMP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_draw    <= draw;
            r_clamped <= (op == trps_pkg::OP_EMIT_CLAMP);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_draw};
    assign m_axis_tuser  = r_clamped;

endmodule

FILE: tb/sv/tb_truncated_poisson_sampler_top.sv
module tb_truncated_poisson_sampler_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_LIM     = trps_pkg::MAX_LIMIT_DEF;
    localparam int PHASES      = 16;
    localparam int PHASE_ITEMS = 110;
    localparam int HOLD_PHASE  = 4;
    localparam int HOLD_CYCLES = 3000;
    localparam int TAIL_CYCLES = 1000;

    // One sampled count as it leaves the block
    typedef struct packed {
        logic [trps_pkg::DRAW_W-1:0] draw;
        logic                        clamped;
    } t_draw;

    // One directed request, with the result typed in where it is plain
    typedef struct packed {
        logic [trps_pkg::LIMIT_W-1:0] limit;
        logic [trps_pkg::RATE_W-1:0]  rate;
        logic [trps_pkg::UNI_W-1:0]   uni;
        bit                           typed;
        logic [trps_pkg::DRAW_W-1:0]  draw;
        logic                         clamped;
    } t_row;

    localparam int DIR_N = 20;
    localparam t_row DIR_TAB [DIR_N] = '{
        // reset limit; a zero rate or a zero uniform picks the first position
        '{4'd8,  24'h000000, 32'h00000000, 1'b1, 5'd1, 1'b0},
        '{4'd8,  24'h000000, 32'hFFFFFFFF, 1'b1, 5'd1, 1'b0},
        '{4'd8,  24'h080000, 32'h80000000, 1'b0, 5'd0, 1'b0},
        '{4'd8,  24'hFFFFFF, 32'h00000000, 1'b1, 5'd1, 1'b0},
        '{4'd8,  24'hFFFFFF, 32'hFFFFFFFF, 1'b0, 5'd0, 1'b0},
        '{4'd8,  24'h3FFFFF, 32'hC0000000, 1'b0, 5'd0, 1'b0},
        // limit of zero keeps only the first weight
        '{4'd0,  24'hFFFFFF, 32'hFFFFFFFF, 1'b1, 5'd1, 1'b0},
        '{4'd0,  24'h080000, 32'h12345678, 1'b1, 5'd1, 1'b0},
        // largest limit, near-top uniform to reach the clamp
        '{4'd15, 24'hFFFFFF, 32'hFFFFFFFF, 1'b0, 5'd0, 1'b0},
        '{4'd15, 24'hFFFFFF, 32'h00000000, 1'b1, 5'd1, 1'b0},
        '{4'd15, 24'h080000, 32'hFFFFFFFF, 1'b0, 5'd0, 1'b0},
        '{4'd15, 24'h500000, 32'h80000000, 1'b0, 5'd0, 1'b0},
        '{4'd15, 24'h000001, 32'h00000001, 1'b0, 5'd0, 1'b0},
        // two equal weights: boundary at one half
        '{4'd1,  24'h080000, 32'h80000000, 1'b0, 5'd0, 1'b0},
        '{4'd1,  24'h080000, 32'h80000001, 1'b0, 5'd0, 1'b0},
        '{4'd1,  24'h080000, 32'hFFFFFFFF, 1'b0, 5'd0, 1'b0},
        '{4'd1,  24'h000003, 32'hAAAAAAAA, 1'b0, 5'd0, 1'b0},
        '{4'd4,  24'h555555, 32'h55555555, 1'b0, 5'd0, 1'b0},
        '{4'd4,  24'hAAAAAA, 32'hAAAAAAAA, 1'b0, 5'd0, 1'b0},
        '{4'd2,  24'hFFFFFF, 32'hFFFFFFFF, 1'b0, 5'd0, 1'b0}
    };

    localparam logic [trps_pkg::LIMIT_W-1:0] PHASE_LIM [PHASES] = '{
        4'd2, 4'd1, 4'd3, 4'd0, 4'd15, 4'd2, 4'd4, 4'd1,
        4'd5, 4'd3, 4'd8, 4'd2, 4'd15, 4'd1, 4'd6, 4'd3
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [3:0]  i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata;   // [23:0] rate, [55:24] uniform
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;   // [4:0] draw, [7:5] zero
    logic [0:0]  m_axis_tuser;   // [0] clamped

    logic [trps_pkg::LIMIT_W-1:0] lim_cur;
    t_draw                        draw_q[$];
    t_draw                        typed_val;
    bit                           typed_on;
    t_draw                        want;
    t_draw                        got;
    int                           fault_cnt;
    int                           snd_pct;
    int                           rcv_pct;
    int                           run_phase;
    bit                           hold_done;

    truncated_poisson_sampler_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Free-running clock
    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Inverse-transform draw over the truncated Poisson weights
    function automatic t_draw poisson_draw(input logic [trps_pkg::LIMIT_W-1:0] limit,
                                           input logic [trps_pkg::RATE_W-1:0] rate,
                                           input logic [trps_pkg::UNI_W-1:0] uni);
        logic [63:0] wt [0:MAX_LIM];
        logic [88:0] prod;
        logic [63:0] scaled;
        logic [64:0] acc;
        logic [63:0] total;
        logic [63:0] cum;
        logic [95:0] quot;
        int          lim;
        int          j;
        t_draw       res;
        lim = (int'(limit) > MAX_LIM) ? MAX_LIM : int'(limit);
        wt[0] = trps_pkg::ONE_Q24;
        total = trps_pkg::ONE_Q24;
        for (j = 1; j <= lim; j++) begin
            // scale by the rate, saturating, then divide by the count
            prod = ({25'b0, wt[j-1]} * {65'b0, rate}) >> trps_pkg::RATE_FRAC;
            scaled = (|prod[88:64]) ? '1 : prod[63:0];
            wt[j] = scaled / 64'(j);
            acc = {1'b0, total} + {1'b0, wt[j]};
            total = acc[64] ? '1 : acc[63:0];
        end
        cum = '0;
        for (j = 0; j <= lim; j++) begin
            quot = {wt[j], 32'b0} / {32'b0, total};
            cum = cum + quot[63:0];
            if ({32'b0, uni} <= cum) begin
                res.draw = trps_pkg::DRAW_W'(j + 1);
                res.clamped = 1'b0;
                return res;
            end
        end
        res.draw = trps_pkg::DRAW_W'(lim + 1);
        res.clamped = 1'b1;
        return res;
    endfunction

    // Track the limit, predict on each request and check each result
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                lim_cur = i_cfg_data;
            if (s_axis_tvalid && s_axis_tready) begin
                if (typed_on)
                    draw_q.push_back(typed_val);
                else
                    draw_q.push_back(poisson_draw(lim_cur, s_axis_tdata[23:0],
                                                  s_axis_tdata[55:24]));
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.draw = m_axis_tdata[4:0];
                got.clamped = m_axis_tuser[0];
                if (draw_q.size() == 0) begin
                    $error("result with nothing pending: draw %0d clamped %0d",
                           got.draw, got.clamped);
                    fault_cnt++;
                end else begin
                    want = draw_q.pop_front();
                    if (got.draw !== want.draw) begin
                        $error("draw: expected %0d, got %0d", want.draw, got.draw);
                        fault_cnt++;
                    end
                    if (got.clamped !== want.clamped) begin
                        $error("clamped: expected %0d, got %0d", want.clamped, got.clamped);
                        fault_cnt++;
                    end
                    if (m_axis_tdata[7:5] !== 3'b000) begin
                        $error("pad: expected 0, got %0d", m_axis_tdata[7:5]);
                        fault_cnt++;
                    end
                end
            end
        end
    end

    // Result side: random stalls, plus one long hold-off to back the block up
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (run_phase == HOLD_PHASE && !hold_done) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_done = 1'b1;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= rcv_pct);
            end
        end
    end

    // Offer one request after a random gap and hold it until taken
    task automatic offer(input logic [trps_pkg::RATE_W-1:0] rate,
                         input logic [trps_pkg::UNI_W-1:0] uni,
                         input bit typed, input t_draw tval);
        while ($urandom_range(99) < snd_pct) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {uni, rate};
        typed_on      <= typed;
        typed_val     <= tval;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Drop the request line and wait for every pending result
    task automatic drain;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (draw_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_limit(input logic [trps_pkg::LIMIT_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Stimulus
    initial begin
        logic [trps_pkg::RATE_W-1:0] rate;
        logic [trps_pkg::UNI_W-1:0]  uni;
        int                          span;
        int                          p;
        int                          n;
        int                          r;
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        typed_on      = 1'b0;
        typed_val     = '0;
        lim_cur       = trps_pkg::LIMIT_RST;
        fault_cnt     = 0;
        snd_pct       = 11;
        rcv_pct       = 11;
        run_phase     = -1;
        hold_done     = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows; change the limit only once the block is idle
        for (r = 0; r < DIR_N; r++) begin
            if (DIR_TAB[r].limit != lim_cur) begin
                drain();
                set_limit(DIR_TAB[r].limit);
            end
            offer(DIR_TAB[r].rate, DIR_TAB[r].uni, DIR_TAB[r].typed,
                  '{DIR_TAB[r].draw, DIR_TAB[r].clamped});
        end
        drain();

        // Random phases, each with its own limit and idling pattern
        for (p = 0; p < PHASES; p++) begin
            set_limit(PHASE_LIM[p]);
            case (p % 4)
                0:       begin snd_pct = 0;  rcv_pct = 0;  end
                1:       begin snd_pct = 85; rcv_pct = 0;  end
                2:       begin snd_pct = 0;  rcv_pct = 85; end
                default: begin snd_pct = 11; rcv_pct = 11; end
            endcase
            run_phase = p;
            span = (int'(lim_cur) + 2) << trps_pkg::RATE_FRAC;
            if (span > 24'hFFFFFF)
                span = 24'hFFFFFF;
            for (n = 0; n < PHASE_ITEMS; n++) begin
                // rates mostly near the limit so draws spread over all positions
                case ($urandom_range(9))
                    0:       rate = trps_pkg::RATE_W'($urandom);
                    1:       rate = $urandom_range(1) ? '1 : '0;
                    default: rate = trps_pkg::RATE_W'($urandom_range(span));
                endcase
                // uniform near the top now and then to provoke the clamp
                case ($urandom_range(7))
                    0:       uni = 32'hFFFFFFFF - $urandom_range(4095);
                    1:       uni = $urandom_range(255);
                    default: uni = $urandom;
                endcase
                offer(rate, uni, 1'b0, '0);
            end
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fault_cnt == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Watchdog
    initial begin
        #40_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
